FILE: hw/rtl/qwlfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qwlfo_pkg
// Shared types and constants of the quarter-wave table LFO: table geometry,
// operation codes, register map and the item formats of both channels.
// ----------------------------------------------------------------------------
package qwlfo_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int DEPTH_W  = 8;
    localparam int SHAPE_W  = 2;
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 8;
    localparam int PADDR_W  = 4;

    // Full-scale sample and the depth code that means plain inversion.
    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 10'd1023;
    localparam logic [DEPTH_W-1:0]  DEPTH_INVERT = 8'd255;
    localparam logic [DEPTH_W-1:0]  DEPTH_NONE   = 8'd0;

    // Operation codes of an input item.
    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_TRI    = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_SINE   = 2'd2;

    // Waveshape codes.
    localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd1;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_WAVESHAPE    = 2'd0;
    localparam logic [1:0] REG_DEPTH        = 2'd1;
    localparam logic [1:0] REG_DEPTH_ENABLE = 2'd2;

    // Input item.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   table_address;
        logic [SAMPLE_W-1:0] table_data;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [SAMPLE_W-1:0] duty;
        logic                second_half;
    } out_item_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [SHAPE_W-1:0] waveshape;
        logic [DEPTH_W-1:0] depth;
        logic               depth_enable;
    } cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/qwlfo_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qwlfo_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and holds its value while no read is issued.
// ----------------------------------------------------------------------------
module qwlfo_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/qwlfo_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qwlfo_regs
// APB register file holding waveshape, depth and depth enable. Writes land
// in the access phase; reads return the stored values.
// ----------------------------------------------------------------------------
module qwlfo_regs
    import qwlfo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_strobe;

    assign reg_index = paddr[3:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes; an index beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waveshape    <= SHAPE_TRIANGLE;
            cfg_reg.depth        <= DEPTH_INVERT;
            cfg_reg.depth_enable <= 1'b1;
        end
        else if (wr_strobe)
        begin
            unique case (reg_index)
                REG_WAVESHAPE:    cfg_reg.waveshape    <= pwdata[SHAPE_W-1:0];
                REG_DEPTH:        cfg_reg.depth        <= pwdata[DEPTH_W-1:0];
                REG_DEPTH_ENABLE: cfg_reg.depth_enable <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        unique case (reg_index)
            REG_WAVESHAPE:    prdata = {{(32-SHAPE_W){1'b0}}, cfg_reg.waveshape};
            REG_DEPTH:        prdata = {{(32-DEPTH_W){1'b0}}, cfg_reg.depth};
            REG_DEPTH_ENABLE: prdata = {31'd0, cfg_reg.depth_enable};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/quarter_wave_lfo_depth_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quarter_wave_lfo_depth_generator_unit
// Quarter-wave table LFO producing one 10-bit duty value per tick item.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries items of three kinds: a tick, a triangle table
// write and a sine table write. Writes give no result; each tick gives one
// result item carrying the duty value and the second-half flag.
// The phase index, direction and half-cycle flag live in registers and are
// stepped when a tick is accepted; the same cycle issues the read of both
// table RAMs. The registered table word is then shaped (select, half-cycle
// inversion, depth multiply) into the output register when that register
// is free. Throughput is one item per cycle while the receiver does not
// stall, set by the single read port of each table RAM; a tick may read an
// entry written by the item just before it. Reset clears the phase state
// and loads the register defaults (triangle, depth 255, depth stage on).
// The tables hold no defined value until written. When the receiver stalls,
// the output register and the read stage hold their items; input is still
// taken while the read stage is empty or can move into the output register.
// The user must write configuration over APB only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module quarter_wave_lfo_depth_generator_unit
    import qwlfo_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    cfg_t cfg;

    // Phase state.
    logic [IDX_W-1:0] phase_index_reg, phase_index_next;
    logic             going_down_reg, going_down_next;
    logic             half_cycle_reg, half_cycle_next;

    // Read stage and output register.
    logic             s1_valid_reg;
    logic             s1_half_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic             accept;
    logic             out_free;
    logic             is_tick;
    logic             addr_ok;
    logic [IDX_W-1:0] wr_addr;
    logic             tri_wr_en, sine_wr_en;
    logic [SAMPLE_W-1:0] tri_word, sine_word;

    logic [SAMPLE_W-1:0]         sample;
    logic [SAMPLE_W-1:0]         half_adj;
    logic [SAMPLE_W+DEPTH_W-1:0] product;
    logic [SAMPLE_W-1:0]         duty;

    qwlfo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the read stage moves on when the output slot is free.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign is_tick  = accept && (in_data.op == OP_TICK);

    // Table writes; an address beyond the table is dropped.
    assign addr_ok    = int'(in_data.table_address) < TABLE_ENTRIES;
    assign wr_addr    = IDX_W'(in_data.table_address);
    assign tri_wr_en  = accept && addr_ok && (in_data.op == OP_WR_TRI);
    assign sine_wr_en = accept && addr_ok && (in_data.op == OP_WR_SINE);

    qwlfo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_tri_ram (
        .clk     (clk),
        .wr_en   (tri_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.table_data),
        .rd_en   (is_tick),
        .rd_addr (phase_index_reg),
        .rd_data (tri_word)
    );

    qwlfo_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_sine_ram (
        .clk     (clk),
        .wr_en   (sine_wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_data.table_data),
        .rd_en   (is_tick),
        .rd_addr (phase_index_reg),
        .rd_data (sine_word)
    );

    // Direction turns at both ends; each return to zero toggles the half cycle.
    always_comb
    begin
        going_down_next = going_down_reg;
        half_cycle_next = half_cycle_reg;
        if (phase_index_reg == IDX_TOP)
        begin
            going_down_next = 1'b1;
        end
        else if (phase_index_reg == IDX_ZERO)
        begin
            going_down_next = 1'b0;
            half_cycle_next = !half_cycle_reg;
        end
        if (going_down_next)
        begin
            phase_index_next = phase_index_reg - 1'b1;
        end
        else
        begin
            phase_index_next = phase_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg <= '0;
            going_down_reg  <= 1'b0;
            half_cycle_reg  <= 1'b0;
        end
        else if (is_tick)
        begin
            phase_index_reg <= phase_index_next;
            going_down_reg  <= going_down_next;
            half_cycle_reg  <= half_cycle_next;
        end
    end

    // Read stage bookkeeping; the table word itself sits in the RAM output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= is_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            s1_half_reg <= half_cycle_next;
        end
    end

    // Shaping: waveform select, half-cycle inversion, depth stage.
    always_comb
    begin
        if (cfg.waveshape == SHAPE_TRIANGLE)
        begin
            sample = tri_word;
        end
        else if (cfg.waveshape == SHAPE_SINE)
        begin
            sample = sine_word;
        end
        else
        begin
            sample = FULL_SCALE;
        end

        half_adj = s1_half_reg ? (FULL_SCALE - sample) : sample;
        product  = half_adj * cfg.depth;

        if (!cfg.depth_enable)
        begin
            duty = half_adj;
        end
        else if (cfg.depth == DEPTH_INVERT)
        begin
            duty = FULL_SCALE - half_adj;
        end
        else if (cfg.depth == DEPTH_NONE)
        begin
            duty = FULL_SCALE;
        end
        else
        begin
            duty = FULL_SCALE - product[SAMPLE_W+DEPTH_W-1:DEPTH_W];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_data_reg.duty        <= duty;
            out_data_reg.second_half <= s1_half_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

FILE: sim/quarter_wave_lfo_depth_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quarter_wave_lfo_depth_generator_unit_tb
// Self-checking bench for the quarter-wave table LFO. A behavioral copy of
// the phase stepping, table stores, half-cycle inversion and depth stage
// predicts every duty item. Each result is checked against the oldest
// prediction. Directed items cover the field extremes, every operation and
// each waveshape. A full square sweep covers the turn at the top entry and
// the half-cycle toggle. A long output stall fills the pipeline, and random
// phases run under several register settings. Ticks only ever use table
// entries that were written before.
// ----------------------------------------------------------------------------
module quarter_wave_lfo_depth_generator_unit_tb;
    import qwlfo_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE = 2'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_SPARE  = 2'd3;
    localparam logic [OP_W-1:0]    OP_SPARE     = 2'd3;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 640;
    localparam int RANDOM_PHASES = 8;

    // Clock, reset and block ports.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    out_item_t          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Predicted LFO state and register copy.
    logic [IDX_W-1:0]    lfo_index       = '0;
    logic                lfo_falling     = 1'b0;
    logic                lfo_second_half = 1'b0;
    logic [SAMPLE_W-1:0] triangle_words [TABLE_ENTRIES];
    logic [SAMPLE_W-1:0] sine_words     [TABLE_ENTRIES];
    bit                  triangle_loaded[TABLE_ENTRIES];
    bit                  sine_loaded    [TABLE_ENTRIES];
    logic [SHAPE_W-1:0]  cfg_shape       = SHAPE_TRIANGLE;
    logic [DEPTH_W-1:0]  cfg_depth       = DEPTH_INVERT;
    logic                cfg_depth_on    = 1'b1;

    out_item_t duty_expected[$];
    int        errors      = 0;
    int        cycle_count = 0;
    bit        hold_req    = 1'b0;
    bit        tx_calm     = 1'b0;
    bit        rx_calm     = 1'b0;

    quarter_wave_lfo_depth_generator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Idle cycles before an item; calm stretches have no idling at all.
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Table words lean on the extremes now and then.
    function automatic logic [SAMPLE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FULL_SCALE;
            default: return SAMPLE_W'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic in_item_t make_item(input logic [OP_W-1:0] op,
                                           input logic [ADDR_W-1:0] address,
                                           input logic [SAMPLE_W-1:0] word);
        in_item_t item;
        item.op            = op;
        item.table_address = address;
        item.table_data    = word;
        return item;
    endfunction

    // Apply one accepted item to the predicted state; a tick queues its duty.
    function automatic void predict_duty(input in_item_t item);
        logic [SAMPLE_W-1:0] sample;
        int unsigned         scaled;
        out_item_t           result;
        case (item.op)
            OP_WR_TRI:
            begin
                triangle_words[item.table_address]  = item.table_data;
                triangle_loaded[item.table_address] = 1'b1;
            end
            OP_WR_SINE:
            begin
                sine_words[item.table_address]  = item.table_data;
                sine_loaded[item.table_address] = 1'b1;
            end
            OP_TICK:
            begin
                case (cfg_shape)
                    SHAPE_TRIANGLE: sample = triangle_words[lfo_index];
                    SHAPE_SINE:     sample = sine_words[lfo_index];
                    default:        sample = FULL_SCALE;
                endcase
                // Turn at the top entry; a return to zero starts a new half cycle.
                if (lfo_index == IDX_W'(TABLE_ENTRIES - 1))
                    lfo_falling = 1'b1;
                else if (lfo_index == '0)
                begin
                    lfo_falling     = 1'b0;
                    lfo_second_half = ~lfo_second_half;
                end
                lfo_index = lfo_falling ? lfo_index - 1'b1 : lfo_index + 1'b1;
                if (lfo_second_half)
                    sample = FULL_SCALE - sample;
                if (cfg_depth_on)
                begin
                    if (cfg_depth == DEPTH_INVERT)
                        sample = FULL_SCALE - sample;
                    else if (cfg_depth == DEPTH_NONE)
                        sample = FULL_SCALE;
                    else
                    begin
                        scaled = (int'(sample) * int'(cfg_depth)) >> 8;
                        sample = FULL_SCALE - SAMPLE_W'(scaled);
                    end
                end
                result.duty        = sample;
                result.second_half = lfo_second_half;
                duty_expected.push_back(result);
            end
            default: ;
        endcase
    endfunction

    // Offer one item and hold it until accepted. Valid stays high on return
    // so that a following item can go out without a gap.
    task automatic send_item(input in_item_t item);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        predict_duty(item);
    endtask

    // A tick never uses an unwritten entry: load it first, just before the tick.
    task automatic tick_item();
        if (cfg_shape == SHAPE_TRIANGLE && !triangle_loaded[lfo_index])
            send_item(make_item(OP_WR_TRI, lfo_index, pick_word()));
        else if (cfg_shape == SHAPE_SINE && !sine_loaded[lfo_index])
            send_item(make_item(OP_WR_SINE, lfo_index, pick_word()));
        send_item(make_item(OP_TICK, ADDR_W'($urandom_range(0, 255)),
                            SAMPLE_W'($urandom_range(0, 1023))));
    endtask

    // Stop offering, wait for every predicted duty, then let writes retire.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (duty_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_WAVESHAPE:    cfg_shape    = value[SHAPE_W-1:0];
            REG_DEPTH:        cfg_depth    = value[DEPTH_W-1:0];
            REG_DEPTH_ENABLE: cfg_depth_on = value[0];
            default: ;
        endcase
    endtask

    // Read a register back and compare it with the register copy.
    task automatic check_reg(input logic [1:0] index);
        logic [31:0] got;
        logic [31:0] wanted;
        logic [31:0] mask;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({index, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        got     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_WAVESHAPE:
            begin
                wanted = 32'(cfg_shape);
                mask   = 32'h3;
            end
            REG_DEPTH:
            begin
                wanted = 32'(cfg_depth);
                mask   = 32'hFF;
            end
            default:
            begin
                wanted = 32'(cfg_depth_on);
                mask   = 32'h1;
            end
        endcase
        if ((got & mask) !== wanted)
        begin
            $display("%0t: register %0d mismatch: expected %0d, actual %0d",
                     $time, index, wanted, got & mask);
            errors++;
        end
    endtask

    task automatic set_config(input logic [SHAPE_W-1:0] shape,
                              input logic [DEPTH_W-1:0] depth,
                              input logic enable);
        write_reg(REG_WAVESHAPE, 32'(shape));
        write_reg(REG_DEPTH, 32'(depth));
        write_reg(REG_DEPTH_ENABLE, 32'(enable));
    endtask

    // Reset values, then both extremes of every register, read back.
    task automatic test_register_access();
        check_reg(REG_WAVESHAPE);
        check_reg(REG_DEPTH);
        check_reg(REG_DEPTH_ENABLE);
        set_config(SHAPE_SPARE, DEPTH_NONE, 1'b0);
        check_reg(REG_WAVESHAPE);
        check_reg(REG_DEPTH);
        check_reg(REG_DEPTH_ENABLE);
        set_config(SHAPE_TRIANGLE, DEPTH_INVERT, 1'b1);
        check_reg(REG_WAVESHAPE);
        check_reg(REG_DEPTH);
        check_reg(REG_DEPTH_ENABLE);
    endtask

    // Table writes at both ends, an ignored op, and ticks under every waveshape.
    task automatic test_directed_items();
        send_item(make_item(OP_WR_TRI, 8'd0, '0));
        send_item(make_item(OP_WR_TRI, 8'd255, FULL_SCALE));
        send_item(make_item(OP_WR_SINE, 8'd0, FULL_SCALE));
        send_item(make_item(OP_WR_SINE, 8'd255, '0));
        send_item(make_item(OP_SPARE, 8'hFF, 10'h3FF));
        send_item(make_item(OP_WR_TRI, 8'd1, 10'h2AA));
        send_item(make_item(OP_WR_SINE, 8'd1, 10'h155));
        tick_item();
        tick_item();
        drain_pipeline();
        set_config(SHAPE_SINE, DEPTH_NONE, 1'b1);
        tick_item();
        drain_pipeline();
        set_config(SHAPE_SPARE, 8'd1, 1'b1);
        tick_item();
        drain_pipeline();
        set_config(SHAPE_SQUARE, 8'd254, 1'b1);
        tick_item();
        drain_pipeline();
        set_config(SHAPE_TRIANGLE, 8'd128, 1'b0);
        tick_item();
        drain_pipeline();
    endtask

    // Square wave without the depth stage: two turns and one half-cycle flip.
    task automatic test_square_sweep();
        set_config(SHAPE_SQUARE, 8'd200, 1'b0);
        repeat (2 * TABLE_ENTRIES + 8)
            tick_item();
        drain_pipeline();
    endtask

    // The receiver stalls for a long stretch while ticks keep coming.
    task automatic test_output_backpressure();
        set_config(SHAPE_SQUARE, 8'd77, 1'b1);
        hold_req = 1'b1;
        repeat (40)
            tick_item();
        drain_pipeline();
    endtask

    // Mostly ticks and table writes, some ignored items, under several settings.
    task automatic test_random_items();
        int done;
        int pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: set_config(SHAPE_TRIANGLE, DEPTH_INVERT, 1'b1);
                1: set_config(SHAPE_SINE, DEPTH_NONE, 1'b1);
                2: set_config(SHAPE_TRIANGLE, 8'd1, 1'b1);
                3: set_config(SHAPE_SINE, 8'd254, 1'b1);
                4: set_config(SHAPE_SPARE, DEPTH_W'($urandom_range(0, 255)), 1'b1);
                5: set_config(SHAPE_TRIANGLE, DEPTH_W'($urandom_range(0, 255)), 1'b0);
                6: set_config(SHAPE_SINE, DEPTH_W'($urandom_range(0, 255)), 1'b1);
                default: set_config(SHAPE_SQUARE, DEPTH_W'($urandom_range(0, 255)), 1'b1);
            endcase
            done = 0;
            while (done < RANDOM_ITEMS / RANDOM_PHASES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    send_item(make_item(OP_SPARE, ADDR_W'($urandom_range(0, 255)),
                                        SAMPLE_W'($urandom_range(0, 1023))));
                else if (pick < 35)
                begin
                    send_item(make_item(($urandom_range(0, 1) != 0) ? OP_WR_TRI : OP_WR_SINE,
                                        ADDR_W'($urandom_range(0, 255)), pick_word()));
                    done++;
                end
                else
                begin
                    tick_item();
                    done++;
                end
            end
            drain_pipeline();
        end
    endtask

    // Receiver: random ready gaps, plus one long hold when requested.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                gap = 0;
            end
            else
                gap = pick_gap(rx_calm);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Compare each accepted result with the oldest predicted duty.
    always @(posedge clk)
    begin
        out_item_t wanted;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (duty_expected.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual duty %0d half %0d",
                         $time, out_data.duty, out_data.second_half);
                errors++;
            end
            else
            begin
                wanted = duty_expected.pop_front();
                if (out_data.duty !== wanted.duty)
                begin
                    $display("%0t: duty mismatch: expected %0d, actual %0d",
                             $time, wanted.duty, out_data.duty);
                    errors++;
                end
                if (out_data.second_half !== wanted.second_half)
                begin
                    $display("%0t: second_half mismatch: expected %0d, actual %0d",
                             $time, wanted.second_half, out_data.second_half);
                    errors++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_items();
        test_square_sweep();
        test_output_backpressure();
        test_random_items();
        drain_pipeline();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
